// File: hdl/lsfg_pkg.sv
package lsfg_pkg;

   localparam int unsigned LedCountDefault = 12;
   localparam int unsigned IdxW            = 4;
   localparam int unsigned ChanW           = 8;
   localparam int unsigned ProdW           = 2 * ChanW;
   localparam int unsigned QueueDepth      = 2;
   localparam logic [ChanW-1:0] BrightReset = 8'd160;
   localparam logic [ChanW-1:0] ChanFull    = 8'd255;

   // Hue region boundaries, 43 hue steps per region.
   localparam logic [ChanW-1:0] HueRegion = 8'd43;
   localparam logic [ChanW-1:0] HueBound1 = 8'(1 * 43);
   localparam logic [ChanW-1:0] HueBound2 = 8'(2 * 43);
   localparam logic [ChanW-1:0] HueBound3 = 8'(3 * 43);
   localparam logic [ChanW-1:0] HueBound4 = 8'(4 * 43);
   localparam logic [ChanW-1:0] HueBound5 = 8'(5 * 43);

   typedef enum logic [1:0] {
      KIND_OFF     = 2'd0,
      KIND_SOLID   = 2'd1,
      KIND_RAINBOW = 2'd2
   } kind_type;

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } rgb_type;

   typedef struct packed {
      kind_type kind;
      rgb_type  color;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic [IdxW-1:0] index;
      logic            last;
      rgb_type         color;
   } led_word_type;

   typedef struct packed {
      logic [IdxW-1:0]  index;
      logic             last;
      logic [ProdW-1:0] red;
      logic [ProdW-1:0] green;
      logic [ProdW-1:0] blue;
   } led_prod_type;

   // (255 * x) >> 8 by shift and subtract.
   function automatic logic [ChanW-1:0] mul255_hi(input logic [ChanW-1:0] x);
      logic [ProdW-1:0] p;
      p = {x, 8'h00} - {8'h00, x};
      return p[ProdW-1:ChanW];
   endfunction

   // Exact x / 255 for any product of two 8-bit channels.
   function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
      logic [ProdW:0] s;
      s = {1'b0, x} + {9'h000, x[ProdW-1:ChanW]} + 17'd1;
      return s[ProdW-1:ChanW];
   endfunction

   // Six-region hue to color at full saturation and value.
   function automatic rgb_type rainbow_rgb(input logic [ChanW-1:0] hue);
      logic [ChanW-1:0] base;
      logic [ChanW-1:0] off;
      logic [ChanW-1:0] rem;
      logic [ChanW-1:0] q;
      logic [ChanW-1:0] t;
      rgb_type          c;
      if (hue < HueBound1) begin
         base = 8'd0;
      end else if (hue < HueBound2) begin
         base = HueBound1;
      end else if (hue < HueBound3) begin
         base = HueBound2;
      end else if (hue < HueBound4) begin
         base = HueBound3;
      end else if (hue < HueBound5) begin
         base = HueBound4;
      end else begin
         base = HueBound5;
      end
      off = hue - base;
      rem = {off[5:0], 2'b00} + {off[6:0], 1'b0};
      q   = mul255_hi(ChanFull - mul255_hi(rem));
      t   = mul255_hi(ChanFull - mul255_hi(ChanFull - rem));
      if (base == 8'd0) begin
         c = '{red: ChanFull, green: t, blue: 8'd0};
      end else if (base == HueBound1) begin
         c = '{red: q, green: ChanFull, blue: 8'd0};
      end else if (base == HueBound2) begin
         c = '{red: 8'd0, green: ChanFull, blue: t};
      end else if (base == HueBound3) begin
         c = '{red: 8'd0, green: q, blue: ChanFull};
      end else if (base == HueBound4) begin
         c = '{red: t, green: 8'd0, blue: ChanFull};
      end else begin
         c = '{red: ChanFull, green: 8'd0, blue: q};
      end
      return c;
   endfunction

endpackage

// File: hdl/lsfg_front.sv
module lsfg_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_light_on,
   input  logic                    req_rainbow_mode,
   input  logic [7:0]              req_red_in,
   input  logic [7:0]              req_green_in,
   input  logic [7:0]              req_blue_in,
   output lsfg_pkg::queue_head_type head,
   input  logic                    head_pop
);
   import lsfg_pkg::*;

   localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CntW = $clog2(QueueDepth + 1);

   cmd_type          mem_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   cmd_type          cmd_new;
   logic             push;
   logic             pop;

   // Classify the request: off wins over rainbow.
   always_comb begin
      cmd_new.color = '{red: req_red_in, green: req_green_in, blue: req_blue_in};
      if (!req_light_on) begin
         cmd_new.kind = KIND_OFF;
      end else if (req_rainbow_mode) begin
         cmd_new.kind = KIND_RAINBOW;
      end else begin
         cmd_new.kind = KIND_SOLID;
      end
   end

   assign req_stall = (count_ff == CntW'(QueueDepth));
   assign push      = req_valid && !req_stall;
   assign pop       = head_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

endmodule

// File: hdl/lsfg_back.sv
module lsfg_back #(
   parameter int unsigned LED_COUNT = lsfg_pkg::LedCountDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               brightness,
   input  lsfg_pkg::queue_head_type head,
   output logic                     head_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lsfg_pkg::led_word_type   rsp_word
);
   import lsfg_pkg::*;

   localparam int unsigned CntW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int unsigned HueStep = 256 / LED_COUNT;
   localparam logic [ChanW-1:0] HueStep8 = ChanW'(HueStep);
   localparam logic [CntW-1:0]  LastPos  = CntW'(LED_COUNT - 1);

   logic [CntW-1:0]  pos_ff, pos_in;
   logic [ChanW-1:0] hue_ff, hue_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s2_valid_ff, s2_valid_in;
   logic             s3_valid_ff, s3_valid_in;
   led_word_type     s1_ff, s1_in;
   led_prod_type     s2_ff, s2_in;
   led_word_type     s3_ff, s3_in;
   logic             s3_ready, s2_ready, s1_ready;
   logic             issue, at_last;

   // Ready chain from the output register back to the sequencer.
   assign s3_ready = !s3_valid_ff || !rsp_stall;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign at_last  = (pos_ff == LastPos);
   assign issue    = head.valid && s1_ready;
   assign head_pop = issue && at_last;

   // Sequencer: walk the LEDs of the head command, one per cycle while stage 1 is ready.
   always_comb begin
      pos_in = pos_ff;
      hue_in = hue_ff;
      if (issue) begin
         if (at_last) begin
            pos_in = '0;
            hue_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
            hue_in = hue_ff + HueStep8;
         end
      end
   end

   // Stage 1: pick the raw color of this LED.
   always_comb begin
      s1_in.index = IdxW'(pos_ff);
      s1_in.last  = at_last;
      case (head.cmd.kind)
         KIND_OFF:     s1_in.color = '0;
         KIND_SOLID:   s1_in.color = head.cmd.color;
         KIND_RAINBOW: s1_in.color = rainbow_rgb(hue_ff);
         default:      s1_in.color = '0;
      endcase
   end

   // Stage 2: multiply by brightness.
   always_comb begin
      s2_in.index = s1_ff.index;
      s2_in.last  = s1_ff.last;
      s2_in.red   = ProdW'(s1_ff.color.red)   * ProdW'(brightness);
      s2_in.green = ProdW'(s1_ff.color.green) * ProdW'(brightness);
      s2_in.blue  = ProdW'(s1_ff.color.blue)  * ProdW'(brightness);
   end

   // Stage 3: divide by 255 into the output register.
   always_comb begin
      s3_in.index       = s2_ff.index;
      s3_in.last        = s2_ff.last;
      s3_in.color.red   = div255(s2_ff.red);
      s3_in.color.green = div255(s2_ff.green);
      s3_in.color.blue  = div255(s2_ff.blue);
   end

   always_comb begin
      s1_valid_in = s1_ready ? head.valid : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         hue_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         hue_ff      <= hue_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_word  = s3_ff;

endmodule

// File: hdl/led_strip_frame_generator.sv
// Channel    Direction  Handshake             Payload
// req_       in         req_valid/req_stall   light_on, rainbow_mode, red/green/blue_in
// rsp_       out        rsp_valid/rsp_stall   led_index, red/green/blue_out, last_led
// csr_       in         csr_write_enable      csr_write_data (brightness)
//
// Each request expands into LED_COUNT response words, one per cycle while
// rsp_ does not stall; the LED sequencer sets that rate.
// From the queue head each word passes the stage 1, 2 and 3 registers.
// Reset is synchronous, active high; brightness returns to 160.
// A two-entry request queue lets req_ flow on while rsp_ stalls, until it is full.
module led_strip_frame_generator #(
   parameter int unsigned LED_COUNT = lsfg_pkg::LedCountDefault
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_light_on,
   input  logic       req_rainbow_mode,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_led_index,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   output logic       rsp_last_led,
   // brightness register
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   import lsfg_pkg::*;

   logic [ChanW-1:0] brightness_ff, brightness_in;
   queue_head_type   head;
   logic             head_pop;
   led_word_type     word;

   // Hold brightness; the user must write it only while idle; the block does not enforce it.
   assign brightness_in = csr_write_enable ? csr_write_data : brightness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BrightReset;
      end else begin
         brightness_ff <= brightness_in;
      end
   end

   // Front: classify each request and queue it.
   lsfg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_light_on     (req_light_on),
      .req_rainbow_mode (req_rainbow_mode),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .head             (head),
      .head_pop         (head_pop)
   );

   // Back: walk the LEDs, convert hue, scale and register the response.
   lsfg_back #(
      .LED_COUNT (LED_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .brightness (brightness_ff),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (word)
   );

   assign rsp_led_index = word.index;
   assign rsp_red_out   = word.color.red;
   assign rsp_green_out = word.color.green;
   assign rsp_blue_out  = word.color.blue;
   assign rsp_last_led  = word.last;

endmodule

// File: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lsfg_pkg::*;

   localparam int LedTotal    = LedCountDefault;
   localparam int HueStep     = 256 / LedTotal;
   localparam int HueSpan     = 43;
   localparam int FracScale   = 6;
   localparam int HoldCycles  = 150;
   localparam int SettleCycles = 6;
   localparam int TailCycles  = 24;
   localparam int ChunkItems  = 16;

   // One row of the directed table: an optional brightness write ahead of the
   // request, the request itself, and, where it is obvious, the color that
   // every LED of the frame must carry.
   typedef struct packed {
      logic       gain_write;
      logic [7:0] gain;
      logic       on;
      logic       rainbow;
      rgb_type    color;
      logic       typed;
      rgb_type    typed_color;
   } plan_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_light_on = 1'b0;
   logic       req_rainbow_mode = 1'b0;
   logic [7:0] req_red_in = 8'd0;
   logic [7:0] req_green_in = 8'd0;
   logic [7:0] req_blue_in = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_led_index;
   logic [7:0] rsp_red_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_blue_out;
   logic       rsp_last_led;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'd0;

   // Predictor state: the brightness the block holds and the LED words that
   // are still owed to the response side, oldest first.
   logic [7:0]   brightness_now = BrightReset;
   led_word_type led_words_due[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int mismatch_count = 0;

   led_strip_frame_generator #(
      .LED_COUNT(LedTotal)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_light_on     (req_light_on),
      .req_rainbow_mode (req_rainbow_mode),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_led_index    (rsp_led_index),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_last_led     (rsp_last_led),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Give up after far more time than the slowest legal run needs.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Apply the global gain with truncation, as the strip driver does.
   function automatic logic [7:0] scale_channel(input logic [7:0] c);
      return 8'((int'(c) * int'(brightness_now)) / int'(ChanFull));
   endfunction

   // Six-region hue conversion at full saturation and value: the low
   // component is always zero, the falling and rising ramps come from the
   // scaled remainder inside the region.
   function automatic rgb_type hue_color(input logic [7:0] hue);
      int      sector;
      int      frac;
      int      fall;
      int      rise;
      rgb_type c;
      sector = int'(hue) / HueSpan;
      frac   = ((int'(hue) - sector * HueSpan) * FracScale) & 255;
      fall   = (255 * (255 - ((255 * frac) >> 8))) >> 8;
      rise   = (255 * (255 - ((255 * (255 - frac)) >> 8))) >> 8;
      case (sector)
         0: c = {ChanFull, 8'(rise), 8'd0};
         1: c = {8'(fall), ChanFull, 8'd0};
         2: c = {8'd0, ChanFull, 8'(rise)};
         3: c = {8'd0, 8'(fall), ChanFull};
         4: c = {8'(rise), 8'd0, ChanFull};
         default: c = {ChanFull, 8'd0, 8'(fall)};
      endcase
      return c;
   endfunction

   // Expand one accepted request into the frame it must produce. Off wins
   // over rainbow; a typed color, where given, replaces the computed one.
   function automatic void queue_frame(input logic on, input logic rainbow,
                                       input rgb_type color, input logic typed,
                                       input rgb_type typed_color);
      led_word_type w;
      rgb_type      c;
      for (int i = 0; i < LedTotal; i++) begin
         if (typed) begin
            c = typed_color;
         end else if (!on) begin
            c = '0;
         end else begin
            c = rainbow ? hue_color(8'(i * HueStep)) : color;
            c.red   = scale_channel(c.red);
            c.green = scale_channel(c.green);
            c.blue  = scale_channel(c.blue);
         end
         w.index = 4'(i);
         w.last  = (i == LedTotal - 1);
         w.color = c;
         led_words_due.push_back(w);
      end
   endfunction

   function automatic plan_row_type plan_row(input logic gain_write, input logic [7:0] gain,
                                             input logic on, input logic rainbow,
                                             input logic [23:0] color, input logic typed,
                                             input logic [23:0] typed_color);
      plan_row_type r;
      r.gain_write  = gain_write;
      r.gain        = gain;
      r.on          = on;
      r.rainbow     = rainbow;
      r.color       = color;
      r.typed       = typed;
      r.typed_color = typed_color;
      return r;
   endfunction

   // Favor the channel extremes now and then, otherwise any value.
   function automatic logic [7:0] random_channel();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
         return 8'h00;
      end else if (pick == 1) begin
         return 8'hff;
      end
      return 8'($urandom_range(255));
   endfunction

   // Offer one request after a random gap; hold it until the block takes it,
   // then queue the frame it owes. Valid stays high when the next request
   // follows without a gap.
   task automatic offer_request(input logic on, input logic rainbow, input rgb_type color,
                                input logic typed, input rgb_type typed_color);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_light_on     <= on;
      req_rainbow_mode <= rainbow;
      req_red_in       <= color.red;
      req_green_in     <= color.green;
      req_blue_in      <= color.blue;
      do begin
         @(posedge clock);
      end while (req_stall);
      queue_frame(on, rainbow, color, typed, typed_color);
   endtask

   // Drop valid and wait until every owed LED word has come back.
   task automatic drain_frames();
      req_valid <= 1'b0;
      while (led_words_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Change brightness only on an idle block, then let the predictor follow.
   task automatic set_brightness(input logic [7:0] value);
      drain_frames();
      repeat (SettleCycles) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      brightness_now = value;
   endtask

   // Response side: check every accepted LED word against the oldest one
   // owed, then pick the stall for the next cycle. A long hold-off, when
   // asked for, is counted down here while the sender keeps offering.
   always @(posedge clock) begin : response_side
      led_word_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (led_words_due.size() == 0) begin
               $error("LED word %0d arrived with no request owing it", rsp_led_index);
               mismatch_count++;
            end else begin
               due = led_words_due.pop_front();
               if (rsp_led_index !== due.index) begin
                  $error("led_index: expected %0d, got %0d", due.index, rsp_led_index);
                  mismatch_count++;
               end
               if (rsp_red_out !== due.color.red) begin
                  $error("red_out: expected %0d, got %0d", due.color.red, rsp_red_out);
                  mismatch_count++;
               end
               if (rsp_green_out !== due.color.green) begin
                  $error("green_out: expected %0d, got %0d", due.color.green, rsp_green_out);
                  mismatch_count++;
               end
               if (rsp_blue_out !== due.color.blue) begin
                  $error("blue_out: expected %0d, got %0d", due.color.blue, rsp_blue_out);
                  mismatch_count++;
               end
               if (rsp_last_led !== due.last) begin
                  $error("last_led: expected %0d, got %0d", due.last, rsp_last_led);
                  mismatch_count++;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (hold_served != hold_requests) begin
            rsp_stall   <= 1'b1;
            hold_left   <= HoldCycles;
            hold_served <= hold_served + 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      plan_row_type directed_plan[$];
      plan_row_type row;
      rgb_type      color;
      logic         on;
      logic         rainbow;
      logic [7:0]   gain;

      // Hold reset once, at the start, then release it.
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. Rows before the first gain write run at the reset
      // brightness. Off frames, zero gain, unity gain on a solid color and full
      // white at the reset brightness are typed in; the rest use the predictor.
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b0, 1'b1, 24'hffffff, 1'b1, 24'h000000));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b0, 1'b0, 24'ha55ac3, 1'b1, 24'h000000));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b1, 1'b0, 24'h000000, 1'b1, 24'h000000));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b1, 1'b0, 24'hffffff, 1'b1, 24'ha0a0a0));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b1, 1'b1, 24'h123456, 1'b0, 24'h000000));
      directed_plan.push_back(plan_row(1'b1, 8'd255, 1'b1, 1'b0, 24'hff00a5, 1'b1, 24'hff00a5));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b1, 1'b0, 24'h01807f, 1'b1, 24'h01807f));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b1, 1'b1, 24'h00ff00, 1'b0, 24'h000000));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b0, 1'b0, 24'hffffff, 1'b1, 24'h000000));
      directed_plan.push_back(plan_row(1'b1, 8'd0,   1'b1, 1'b0, 24'hffffff, 1'b1, 24'h000000));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b1, 1'b1, 24'hffffff, 1'b1, 24'h000000));
      directed_plan.push_back(plan_row(1'b1, 8'd1,   1'b1, 1'b0, 24'hfffe80, 1'b0, 24'h000000));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b1, 1'b1, 24'h000000, 1'b0, 24'h000000));
      directed_plan.push_back(plan_row(1'b1, 8'd128, 1'b1, 1'b0, 24'h55aa01, 1'b0, 24'h000000));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b1, 1'b1, 24'h5a5a5a, 1'b0, 24'h000000));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b0, 1'b1, 24'h000000, 1'b1, 24'h000000));
      directed_plan.push_back(plan_row(1'b1, 8'd254, 1'b1, 1'b0, 24'hffffff, 1'b0, 24'h000000));
      directed_plan.push_back(plan_row(1'b0, 8'd0,   1'b1, 1'b1, 24'hc3c3c3, 1'b0, 24'h000000));

      foreach (directed_plan[k]) begin
         row = directed_plan[k];
         if (row.gain_write) begin
            set_brightness(row.gain);
         end
         offer_request(row.on, row.rainbow, row.color, row.typed, row.typed_color);
      end

      // Random part in three idling phases: sender slow and receiver slower,
      // then the other way round, then both at full speed. Each phase steps
      // through four brightness settings, both extremes among them.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 65 : 0;
         recv_idle_pct <= (phase == 0) ? 65 : (phase == 1) ? 34 : 0;
         for (int chunk = 0; chunk < 4; chunk++) begin
            case (chunk)
               0: gain = (phase[0] == 1'b0) ? ChanFull : 8'd0;
               2: gain = (phase[0] == 1'b0) ? 8'd0 : ChanFull;
               default: gain = 8'($urandom_range(255));
            endcase
            set_brightness(gain);
            // Starve the response side for a long stretch so the request
            // queue fills and the block stalls its input.
            if ((phase == 0 && chunk == 2) || (phase == 2 && chunk == 1)) begin
               hold_requests <= hold_requests + 1;
            end
            for (int n = 0; n < ChunkItems; n++) begin
               on      = ($urandom_range(99) < 85);
               rainbow = ($urandom_range(99) < 30);
               color.red   = random_channel();
               color.green = random_channel();
               color.blue  = random_channel();
               offer_request(on, rainbow, color, 1'b0, '0);
            end
         end
      end

      // Collect the remaining frames, then watch a little longer for strays.
      drain_frames();
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: led_strip_frame_generator.f
hdl/lsfg_pkg.sv
hdl/lsfg_front.sv
hdl/lsfg_back.sv
hdl/led_strip_frame_generator.sv
tb/tb_top.sv
